// ----- rtl/tbpr_pkg.sv -----
// Package for the tile background pixel renderer: opcodes, register indexes,
// color table and the front-to-back work descriptor. No dependencies.
`default_nettype none
package tbpr_pkg;
  typedef enum logic [1:0] {
    OP_MAP  = 2'd0,
    OP_ATTR = 2'd1,
    OP_PAT  = 2'd2,
    OP_PIX  = 2'd3
  } op_e;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] REG_SCROLL_H = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SCROLL_V = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PAL0 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PAL1 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PAL2 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PAL3 = 3'd5;

  function automatic logic [23:0] color_lut(input logic [3:0] idx);
    logic [23:0] c;
    case (idx)
      4'd0: c = 24'h1a1717;   4'd1: c = 24'h8d8383;
      4'd2: c = 24'hd3c1c1;   4'd3: c = 24'hede5e5;
      4'd4: c = 24'h92afed;   4'd5: c = 24'h7a84d3;
      4'd6: c = 24'h7958c1;   4'd7: c = 24'h6c2c9e;
      4'd8: c = 24'h8d1e1e;   4'd9: c = 24'hc15133;
      4'd10: c = 24'he588a6;  4'd11: c = 24'he5c1d4;
      4'd12: c = 24'h27953f;  4'd13: c = 24'h4bb93e;
      4'd14: c = 24'ha2d34e;  default: c = 24'hfaff6b;
    endcase
    return c;
  endfunction

  // One classified item handed from front to back.
  typedef struct packed {
    op_e         op;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic        last;
  } work_t;
endpackage
`default_nettype wire

// ----- rtl/tbpr_if.sv -----
// Valid/ready channel with a generic payload. No dependencies.
`default_nettype none
interface tbpr_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/tbpr_front.sv -----
// Front end: accepts items, assigns scan positions to render items, pushes a
// work descriptor into the queue. Depends on tbpr_pkg.
`default_nettype none
module tbpr_front #(
  parameter int SCREEN_SIDE = 128
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [1:0]      opcode_i,
  input  wire logic [11:0]     write_address_i,
  input  wire logic [7:0]      write_data_i,
  input  wire logic            enable_i,
  output logic                 push_o,
  output tbpr_pkg::work_t      work_o,
  input  wire logic            full_i
);
  import tbpr_pkg::*;
  localparam logic [7:0] Last = 8'(SCREEN_SIDE - 1);

  logic [7:0] col_q, col_d, row_q, row_d;
  logic       take;

  assign in_ready_o = enable_i && !full_i;
  assign take = in_valid_i && in_ready_o;
  assign push_o = take;

  always_comb begin
    work_o.op = op_e'(opcode_i);
    work_o.addr = write_address_i;
    work_o.data = write_data_i;
    work_o.sx = col_q;
    work_o.sy = row_q;
    work_o.last = (col_q == Last) && (row_q == Last);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take && op_e'(opcode_i) == OP_PIX) begin
      if (col_q >= Last) begin
        col_d = '0;
        row_d = (row_q >= Last) ? 8'd0 : row_q + 8'd1;
      end else begin
        col_d = col_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tbpr_queue.sv -----
// Two-entry queue between front and back. Depends on tbpr_pkg.
`default_nettype none
module tbpr_queue (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  tbpr_pkg::work_t data_i,
  output logic            full_o,
  output logic            valid_o,
  output tbpr_pkg::work_t data_o,
  input  wire logic       pop_i
);
  import tbpr_pkg::*;
  work_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/tbpr_back.sv -----
// Back end: stores writes, renders pixels through a four-stage pipeline
// (map/attr read, pattern read, screen read-modify-write, color) with an
// output skid. Clears the screen buffer and the stores after reset. Depends on tbpr_pkg.
`default_nettype none
module tbpr_back #(
  parameter int SCREEN_SIDE = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [tbpr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        q_valid_i,
  input  tbpr_pkg::work_t  q_data_i,
  output logic             q_pop_o,
  output logic             clear_done_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [23:0]      pixel_color_o,
  output logic [7:0]       screen_x_o,
  output logic [7:0]       screen_y_o,
  output logic             frame_end_o
);
  import tbpr_pkg::*;
  localparam int Pix = SCREEN_SIDE * SCREEN_SIDE;
  localparam int PosW = $clog2(Pix);

  logic [7:0]  scroll_h_q, scroll_v_q;
  logic [15:0] pal_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_h_q <= '0;
      scroll_v_q <= '0;
      for (int i = 0; i < 4; i++) pal_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCROLL_H: scroll_h_q <= cfg_data_i[7:0];
        REG_SCROLL_V: scroll_v_q <= cfg_data_i[7:0];
        REG_PAL0: pal_q[0] <= cfg_data_i;
        REG_PAL1: pal_q[1] <= cfg_data_i;
        REG_PAL2: pal_q[2] <= cfg_data_i;
        REG_PAL3: pal_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sweep the screen over its whole index range; clear map, attr and pattern
  // stores alongside.
  logic [PosW:0] clr_q;
  logic          clearing;
  assign clearing = !clr_q[PosW];
  logic [12:0]   clr12_q;
  logic          clr12_busy;
  assign clr12_busy = !clr12_q[12];
  assign clear_done_o = !clearing && !clr12_busy;

  // Pipeline control: stalls whole pipe when the output skid is full.
  logic s1_v_q, s2_v_q, s3_v_q;
  logic adv;
  logic sk_v_q;
  logic [24+8+8+1-1:0] sk_q, o_q;
  logic o_v_q;
  assign adv = !sk_v_q;

  // S0: decode + scrolled address
  work_t w;
  assign w = q_data_i;
  assign q_pop_o = q_valid_i && adv && clear_done_o;
  logic pix_go;
  assign pix_go = q_pop_o && w.op == OP_PIX;
  logic [7:0] mx, my;
  assign mx = w.sx + scroll_h_q;
  assign my = w.sy + scroll_v_q;

  logic [7:0] map_mem [1024];
  logic [7:0] attr_mem [1024];
  logic [7:0] pat_mem [4096];
  logic [3:0] scr_mem [Pix];

  logic [7:0] tile_q, attrb_q;
  logic [2:0] col1_q, trow1_q;
  logic [7:0] sx1_q, sy1_q; logic last1_q;

  always_ff @(posedge clk_i) begin
    if (clr12_busy) begin
      map_mem[clr12_q[9:0]] <= '0;
      attr_mem[clr12_q[9:0]] <= '0;
      pat_mem[clr12_q[11:0]] <= '0;
    end else if (q_pop_o && w.op == OP_MAP) begin
      map_mem[w.addr[9:0]] <= w.data;
    end else if (q_pop_o && w.op == OP_ATTR) begin
      attr_mem[w.addr[9:0]] <= w.data;
    end else if (q_pop_o && w.op == OP_PAT) begin
      pat_mem[w.addr] <= w.data;
    end
    if (pix_go) begin
      tile_q <= map_mem[{my[7:3], mx[7:3]}];
      attrb_q <= attr_mem[{1'b0, my[7:3], 4'b0} + {5'b0, mx[7:3]}];
      col1_q <= mx[2:0];
      trow1_q <= my[2:0];
      sx1_q <= w.sx; sy1_q <= w.sy; last1_q <= w.last;
    end
  end

  // S1 -> S2: pattern fetch
  logic [7:0] pat2_q, attr2_q; logic [2:0] col2_q;
  logic [7:0] sx2_q, sy2_q; logic last2_q;
  logic bsel;
  assign bsel = attrb_q[3] ? ~col1_q[2] : col1_q[2];
  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      pat2_q <= pat_mem[{tile_q, trow1_q, bsel}];
      attr2_q <= attrb_q; col2_q <= col1_q;
      sx2_q <= sx1_q; sy2_q <= sy1_q; last2_q <= last1_q;
    end
  end

  // S2: pixel, write screen index if opaque, read back current
  logic [1:0] shsel, pix2;
  assign shsel = attr2_q[3] ? col2_q[1:0] : ~col2_q[1:0];
  assign pix2 = pat2_q[{shsel, 1'b0} +: 2];
  logic [15:0] pw; assign pw = pal_q[attr2_q[1:0]];
  logic [3:0] nidx; assign nidx = pw[{pix2, 2'b00} +: 4];
  logic wr2; assign wr2 = !(pix2 == 2'd0 && attr2_q[2]);
  logic [PosW-1:0] pos2;
  assign pos2 = PosW'(sy2_q) * PosW'(SCREEN_SIDE) + PosW'(sx2_q);
  logic [3:0] idx3_q;
  logic [7:0] sx3_q, sy3_q; logic last3_q;
  always_ff @(posedge clk_i) begin
    if (clearing) scr_mem[clr_q[PosW-1:0]] <= '0;
    else if (adv && s2_v_q && wr2) scr_mem[pos2] <= nidx;
    if (adv && s2_v_q) begin
      idx3_q <= wr2 ? nidx : scr_mem[pos2];
      sx3_q <= sx2_q; sy3_q <= sy2_q; last3_q <= last2_q;
    end
  end

  // S3: color into output register, skid behind it
  logic [40:0] res3;
  assign res3 = {color_lut(idx3_q), sx3_q, sy3_q, last3_q};
  always_ff @(posedge clk_i) begin
    if (adv && s3_v_q && o_v_q && !out_ready_i) sk_q <= res3;
    if (!o_v_q || out_ready_i) o_q <= sk_v_q ? sk_q : res3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0; clr12_q <= '0;
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0;
      o_v_q <= 1'b0; sk_v_q <= 1'b0;
    end else begin
      if (clearing) clr_q <= clr_q + 1'b1;
      if (clr12_busy) clr12_q <= clr12_q + 13'd1;
      if (adv) begin
        s1_v_q <= pix_go;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
      end
      if (!o_v_q || out_ready_i) begin
        o_v_q <= sk_v_q || (adv && s3_v_q);
        sk_v_q <= 1'b0;
      end else if (adv && s3_v_q) begin
        sk_v_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = o_v_q;
  assign {pixel_color_o, screen_x_o, screen_y_o, frame_end_o} = o_q;
endmodule
`default_nettype wire

// ----- rtl/tile_background_pixel_renderer_unit.sv -----
// Top level of the tile background pixel renderer: front, queue, back.
// Depends on tbpr_pkg, tbpr_if, tbpr_front, tbpr_queue, tbpr_back.
//
// Usage: in_ch carries {opcode, write_address, write_data}; opcode 0..2
// writes the map, attribute or pattern store and gives no result, opcode 3
// renders the next raster pixel and gives one item on out_ch
// {pixel_color, screen_x, screen_y, frame_end}. Configuration writes
// (scroll, palettes) are taken on cfg_we_i with cfg_idx_i / cfg_data_i.
// Throughput: one item per cycle while out_ch does not stall. An accepted
// item passes the queue, the map/attr read, the pattern read, the screen
// read-modify-write and the color register before out_ch.valid rises.
// After reset the screen buffer is swept clear, one pixel per cycle, over
// every index up to the next power of two of SCREEN_SIDE*SCREEN_SIDE (16384
// at default); the stores clear in parallel. in_ch.ready stays low
// meanwhile.
// When out_ch stalls, results park in a skid register, the pipe holds, the
// queue fills, and in_ch.ready drops.
`default_nettype none
module tile_background_pixel_renderer_unit #(
  parameter int SCREEN_SIDE = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  tbpr_if.sink             in_ch,
  tbpr_if.source           out_ch
);
  import tbpr_pkg::*;
  logic  push, full, qv, pop, done;
  work_t wk, qd;
  logic [23:0] pix_color;
  logic [7:0]  pix_x, pix_y;
  logic        pix_last;

  tbpr_front #(.SCREEN_SIDE(SCREEN_SIDE)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .opcode_i(in_ch.payload[21:20]), .write_address_i(in_ch.payload[19:8]),
    .write_data_i(in_ch.payload[7:0]), .enable_i(done),
    .push_o(push), .work_o(wk), .full_i(full)
  );
  tbpr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(wk), .full_o(full),
    .valid_o(qv), .data_o(qd), .pop_i(pop)
  );
  tbpr_back #(.SCREEN_SIDE(SCREEN_SIDE)) u_back (
    .clk_i, .rst_ni, .cfg_idx_i, .cfg_we_i, .cfg_data_i,
    .q_valid_i(qv), .q_data_i(qd), .q_pop_o(pop), .clear_done_o(done),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .pixel_color_o(pix_color), .screen_x_o(pix_x),
    .screen_y_o(pix_y), .frame_end_o(pix_last)
  );

  assign out_ch.payload = {pix_color, pix_x, pix_y, pix_last};
endmodule
`default_nettype wire

// ----- rtl/tbpr_checker.sv -----
// Port-level checks for the renderer, bound to the top level.
// Depends on the top level's port list only.
`default_nettype none
module tbpr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [40:0] out_payload
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result dropped or changed while stalled");
  a_frame_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_payload[0] |-> out_payload[16:9] == out_payload[8:1])
    else $error("frame end off the diagonal corner");
  a_no_early: assert property (@(posedge clk_i) $fell(rst_ni) ##1 1 |-> !out_valid)
    else $error("result right after reset");
  a_ready_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(in_ready))
    else $error("input ready unknown");
endmodule

bind tile_background_pixel_renderer_unit tbpr_checker u_chk (
  .clk_i, .rst_ni, .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
`default_nettype wire

// ----- sim/tile_background_pixel_renderer_unit_tb.sv -----
// Testbench for the tile background pixel renderer: drives store writes and
// pixel renders, predicts every pixel and compares it on the result channel.
// Depends on tbpr_pkg, tbpr_if and tile_background_pixel_renderer_unit.
`timescale 1ns / 1ps
module tile_background_pixel_renderer_unit_tb;
  import tbpr_pkg::*;

  localparam int Side = 128;
  localparam int Latency = 5;
  localparam int StallLimit = 60000;

  typedef struct packed {
    logic [23:0] color;
    logic [7:0]  sx;
    logic [7:0]  sy;
    logic        last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  tbpr_if #(.W(22)) in_ch ();
  tbpr_if #(.W(41)) out_ch ();

  tile_background_pixel_renderer_unit #(.SCREEN_SIDE(Side)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state
  logic [7:0]  pred_scroll_h, pred_scroll_v;
  logic [15:0] pal_word [4];
  logic [7:0]  map_mem [1024];
  logic [7:0]  attr_mem [1024];
  logic [7:0]  pat_mem [4096];
  logic [3:0]  screen_idx [Side*Side];
  int          scan_col, scan_row;
  pixel_t      pending_pixels [$];

  int  mismatches = 0;
  int  pixels_seen = 0;
  int  idle_cycles = 0;
  bit  quiet = 0;
  bit  hold_out = 0;

  function automatic logic [23:0] palette_color(input logic [3:0] i);
    logic [23:0] tbl [16];
    tbl = '{24'h1a1717, 24'h8d8383, 24'hd3c1c1, 24'hede5e5,
            24'h92afed, 24'h7a84d3, 24'h7958c1, 24'h6c2c9e,
            24'h8d1e1e, 24'hc15133, 24'he588a6, 24'he5c1d4,
            24'h27953f, 24'h4bb93e, 24'ha2d34e, 24'hfaff6b};
    return tbl[i];
  endfunction

  task automatic render_pixel();
    logic [7:0] mx, my;
    logic [4:0] cc, cr;
    logic [7:0] tile, attr, pat;
    logic [2:0] col, trow;
    logic [1:0] pix;
    logic [15:0] pw;
    int bsel, shift, pos;
    pixel_t p;
    mx = 8'(scan_col) + pred_scroll_h;
    my = 8'(scan_row) + pred_scroll_v;
    cc = mx[7:3];
    cr = my[7:3];
    tile = map_mem[{cr, cc}];
    attr = attr_mem[10'(cr * 16 + cc)];
    col = mx[2:0];
    trow = my[2:0];
    if (attr[3]) begin
      bsel = (col >> 2) ^ 1;
      shift = 2 * (col & 3);
    end else begin
      bsel = col >> 2;
      shift = 2 * (3 - (col & 3));
    end
    pat = pat_mem[12'(tile * 16 + trow * 2 + bsel)];
    pix = 2'(pat >> shift);
    pos = scan_row * Side + scan_col;
    if (!(pix == 0 && attr[2])) begin
      pw = pal_word[attr[1:0]];
      screen_idx[pos] = 4'(pw >> (pix * 4));
    end
    p.color = palette_color(screen_idx[pos]);
    p.sx = 8'(scan_col);
    p.sy = 8'(scan_row);
    p.last = (scan_col == Side - 1) && (scan_row == Side - 1);
    pending_pixels.push_back(p);
    if (scan_col == Side - 1) begin
      scan_col = 0;
      scan_row = (scan_row == Side - 1) ? 0 : scan_row + 1;
    end else begin
      scan_col++;
    end
  endtask

  task automatic random_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  endtask

  // Send one item and update the prediction once it is accepted.
  task automatic send_item(input op_e op, input logic [11:0] addr, input logic [7:0] data);
    random_gap();
    in_ch.valid <= 1'b1;
    in_ch.payload <= {op, addr, data};
    do @(posedge clk_i); while (!in_ch.ready);
    case (op)
      OP_MAP: map_mem[addr[9:0]] = data;
      OP_ATTR: attr_mem[addr[9:0]] = data;
      OP_PAT: pat_mem[addr] = data;
      default: render_pixel();
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (Latency + 3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_SCROLL_H: pred_scroll_h = val[7:0];
      REG_SCROLL_V: pred_scroll_v = val[7:0];
      REG_PAL0: pal_word[0] = val;
      REG_PAL1: pal_word[1] = val;
      REG_PAL2: pal_word[2] = val;
      REG_PAL3: pal_word[3] = val;
      default: ;
    endcase
  endtask

  task automatic random_item(input int render_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < render_weight) send_item(OP_PIX, 12'($urandom), 8'($urandom));
    else send_item(op_e'($urandom_range(0, 2)), 12'($urandom), 8'($urandom));
  endtask

  task automatic test_directed();
    write_reg(REG_PAL0, 16'hffff);
    write_reg(REG_PAL1, 16'h3210);
    write_reg(REG_PAL2, 16'h0000);
    write_reg(REG_PAL3, 16'h9abc);
    send_item(OP_MAP, 12'h000, 8'hff);
    send_item(OP_MAP, 12'hfff, 8'h01);
    send_item(OP_ATTR, 12'h000, 8'h0d);
    send_item(OP_ATTR, 12'hc01, 8'h07);
    send_item(OP_PAT, 12'hff0, 8'hb4);
    send_item(OP_PAT, 12'hff1, 8'h1e);
    send_item(OP_PAT, 12'h010, 8'h00);
    send_item(OP_PAT, 12'h011, 8'hff);
    for (int i = 0; i < 12; i++) send_item(OP_PIX, 12'hfff, 8'hff);
    wait_drained();
  endtask

  task automatic test_random_phase(input int count);
    write_reg(REG_SCROLL_H, 16'($urandom));
    write_reg(REG_SCROLL_V, 16'($urandom));
    for (int i = 2; i < 6; i++) write_reg(3'(i), 16'($urandom));
    write_reg(3'($urandom_range(6, 7)), 16'($urandom));
    for (int i = 0; i < count; i++) random_item(50);
    wait_drained();
  endtask

  // Hold the receiver off while the sender keeps offering renders.
  task automatic test_back_pressure();
    hold_out = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk_i);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 40; i++) send_item(OP_PIX, '0, '0);
    join
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    pixel_t got, want;
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        pixels_seen++;
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pixel %h", got);
        end else begin
          want = pending_pixels.pop_front();
          if (got.color !== want.color || got.sx !== want.sx || got.sy !== want.sy
              || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected %h %0d,%0d %b got %h %0d,%0d %b",
                       want.color, want.sx, want.sy, want.last,
                       got.color, got.sx, got.sy, got.last);
          end
        end
      end
    end
  end

  // Receiver stalls in random bursts.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_out) out_ch.ready <= 1'b0;
      else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
      end else out_ch.ready <= 1'b1;
    end
  end

  initial begin
    @(posedge rst_ni);
    wait (idle_cycles >= StallLimit);
    $display("timeout after %0d idle cycles", idle_cycles);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    pred_scroll_h = 0;
    pred_scroll_v = 0;
    scan_col = 0;
    scan_row = 0;
    for (int i = 0; i < 4; i++) pal_word[i] = 0;
    for (int i = 0; i < 1024; i++) begin
      map_mem[i] = 0;
      attr_mem[i] = 0;
    end
    for (int i = 0; i < 4096; i++) pat_mem[i] = 0;
    for (int i = 0; i < Side * Side; i++) screen_idx[i] = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_phase(300);
    test_back_pressure();
    test_random_phase(300);
    quiet = 1'b1;
    test_random_phase(190);
    repeat (Latency + 5) @(negedge clk_i);
    $display("Covered store writes, scrolled and mirrored renders and output stalls;");
    $display("%0d pixels compared, %0d mismatches.", pixels_seen, mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- tile_background_pixel_renderer_unit.f -----
rtl/tbpr_pkg.sv
rtl/tbpr_if.sv
rtl/tbpr_front.sv
rtl/tbpr_queue.sv
rtl/tbpr_back.sv
rtl/tile_background_pixel_renderer_unit.sv
rtl/tbpr_checker.sv
sim/tile_background_pixel_renderer_unit_tb.sv
